// File: sv/configurable_char_tokenizer_macros.svh
// configurable_char_tokenizer_macros.svh
// assertion macros for the tokenizer checker; expects clk and arst_n in scope
`ifndef CONFIGURABLE_CHAR_TOKENIZER_MACROS_SVH
`define CONFIGURABLE_CHAR_TOKENIZER_MACROS_SVH

// same-cycle implication, disabled during reset
`define CTOK_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define CTOK_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/ctok_pkg.sv
// ctok_pkg: types, codes and constants of the character tokenizer
// used by ctok_scan, configurable_char_tokenizer and ctok_checker
package ctok_pkg;

	// set registers hold byte-wide codes, one per slot
	localparam int SET_SLOTS = 8;
	localparam int SLOT_W    = 8;
	localparam int SET_W     = SET_SLOTS * SLOT_W;

	localparam int CHAR_W = 8;
	localparam int LEN_W  = 12;
	localparam int CAP_W  = 13;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 64;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_BLANK    = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SEP      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_QUOTE    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_ESCAPE   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CASE     = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_CAPACITY = 3'd5;

	// register reset values
	localparam logic [SET_W-1:0]  BLANK_RESET    = 64'd2304;
	localparam logic [SET_W-1:0]  SEP_RESET      = 64'd44;
	localparam logic [SET_W-1:0]  QUOTE_RESET    = 64'd8743;
	localparam logic [CHAR_W-1:0] ESCAPE_RESET   = 8'd0;
	localparam logic [1:0]        CASE_RESET     = 2'd0;
	localparam logic [CAP_W-1:0]  CAPACITY_RESET = 13'd256;

	// case conversion codes and letter offset
	localparam logic [1:0] CASE_UPPER = 2'd1;
	localparam logic [1:0] CASE_LOWER = 2'd2;
	localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

	localparam logic [CAP_W-1:0] CAP_MIN = 13'd1;
	localparam logic [CAP_W-1:0] CAP_MAX = 13'd4096;

	typedef enum logic [1:0] {
		MODE_WHITE = 2'd0,
		MODE_TOKEN = 2'd1,
		MODE_QUOTE = 2'd2,
		MODE_AFTER = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		SCAN_CONSUMED = 2'd0,
		SCAN_ENDED    = 2'd1,
		SCAN_AGAIN    = 2'd2
	} scan_status_t;

	typedef struct packed {
		logic [SET_W-1:0]  blank_chars;
		logic [SET_W-1:0]  separator_chars;
		logic [SET_W-1:0]  quote_chars;
		logic [CHAR_W-1:0] escape_code;
		logic [1:0]        case_mode;
		logic [CAP_W-1:0]  token_capacity;
	} cfg_t;

	typedef struct packed {
		mode_t             scan_mode;
		logic [CHAR_W-1:0] open_quote;
		logic              escape_pending;
		logic [LEN_W-1:0]  token_length;
		logic              quoted_flag;
	} tok_state_t;

	localparam tok_state_t TOK_CLEAR = '{
		scan_mode:      MODE_WHITE,
		open_quote:     '0,
		escape_pending: 1'b0,
		token_length:   '0,
		quoted_flag:    1'b0
	};

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last_in_line;
	} in_t;

	typedef struct packed {
		logic              has_char;
		logic [CHAR_W-1:0] char_out;
		logic              token_end;
		logic [CHAR_W-1:0] breaker_char;
		logic              was_quoted;
		logic              line_end;
	} out_t;

	// results of one character: up to two transactions
	typedef struct packed {
		logic first_valid;
		out_t first;
		logic second_valid;
		out_t second;
	} step_t;

endpackage

// File: sv/ctok_scan.sv
// ctok_scan: combinational scan of one character against the tokenizer state
// depends on ctok_pkg
module ctok_scan (
	input  ctok_pkg::cfg_t       cfg,
	input  ctok_pkg::tok_state_t cur,
	input  ctok_pkg::in_t        item,
	output ctok_pkg::tok_state_t nxt,
	output ctok_pkg::step_t      step
);

	typedef struct packed {
		ctok_pkg::tok_state_t         st;
		logic                         has;
		logic [ctok_pkg::CHAR_W-1:0]  chr;
		logic [ctok_pkg::CHAR_W-1:0]  brk;
		ctok_pkg::scan_status_t       status;
	} scan_t;

	// parallel compare over all slots, empty slots never match
	function automatic logic in_set(input logic [ctok_pkg::SET_W-1:0] set,
		input logic [ctok_pkg::CHAR_W-1:0] c);
		logic hit;
		hit = 1'b0;
		for (int s = 0; s < ctok_pkg::SET_SLOTS; s++) begin
			if (set[ctok_pkg::SLOT_W*s +: ctok_pkg::SLOT_W] != '0 &&
				set[ctok_pkg::SLOT_W*s +: ctok_pkg::SLOT_W] == c) begin
				hit = 1'b1;
			end
		end
		return hit;
	endfunction

	// one pass of the state machine over a character
	function automatic scan_t scan_once(input ctok_pkg::tok_state_t st,
		input logic [ctok_pkg::CHAR_W-1:0] c, input logic last,
		input ctok_pkg::cfg_t cf);
		scan_t r;
		logic is_sep;
		logic is_quo;
		logic is_blk;
		logic is_esc;
		logic do_store;
		logic [ctok_pkg::CAP_W-1:0] cap;
		logic [ctok_pkg::CHAR_W-1:0] cc;
		r.st     = st;
		r.has    = 1'b0;
		r.chr    = '0;
		r.brk    = '0;
		r.status = ctok_pkg::SCAN_CONSUMED;
		do_store = 1'b0;
		is_sep = in_set(cf.separator_chars, c);
		is_quo = in_set(cf.quote_chars, c);
		is_blk = in_set(cf.blank_chars, c);
		is_esc = (cf.escape_code != '0) && (c == cf.escape_code) && !last;

		if (st.escape_pending) begin
			r.st.escape_pending = 1'b0;
			do_store = 1'b1;
		end else if (is_sep) begin
			if (st.scan_mode != ctok_pkg::MODE_QUOTE) begin
				r.brk    = c;
				r.status = ctok_pkg::SCAN_ENDED;
			end else begin
				do_store = 1'b1;
			end
		end else if (is_quo) begin
			case (st.scan_mode)
				ctok_pkg::MODE_WHITE: begin
					r.st.scan_mode   = ctok_pkg::MODE_QUOTE;
					r.st.open_quote  = c;
					r.st.quoted_flag = 1'b1;
				end
				ctok_pkg::MODE_QUOTE: begin
					if (c != st.open_quote) begin
						do_store = 1'b1;
					end else begin
						r.st.scan_mode  = ctok_pkg::MODE_AFTER;
						r.st.open_quote = '0;
					end
				end
				default: begin
					r.brk    = c;
					r.status = ctok_pkg::SCAN_AGAIN;
				end
			endcase
		end else if (is_blk) begin
			if (st.scan_mode == ctok_pkg::MODE_TOKEN) begin
				r.st.scan_mode = ctok_pkg::MODE_AFTER;
			end else if (st.scan_mode == ctok_pkg::MODE_QUOTE) begin
				do_store = 1'b1;
			end
		end else if (st.scan_mode == ctok_pkg::MODE_AFTER) begin
			// ordinary or escape after a finished token: end it, rescan
			r.status = ctok_pkg::SCAN_AGAIN;
		end else begin
			if (st.scan_mode == ctok_pkg::MODE_WHITE) begin
				r.st.scan_mode = ctok_pkg::MODE_TOKEN;
			end
			if (is_esc) begin
				r.st.escape_pending = 1'b1;
			end else begin
				do_store = 1'b1;
			end
		end

		// store with capacity limit and optional case conversion
		cap = cf.token_capacity;
		if (cap == '0) begin
			cap = ctok_pkg::CAP_MIN;
		end else if (cap > ctok_pkg::CAP_MAX) begin
			cap = ctok_pkg::CAP_MAX;
		end
		cc = c;
		if (r.st.scan_mode != ctok_pkg::MODE_QUOTE) begin
			if (cf.case_mode == ctok_pkg::CASE_UPPER && (c inside {[8'h61:8'h7a]})) begin
				cc = c - ctok_pkg::CASE_OFFSET;
			end else if (cf.case_mode == ctok_pkg::CASE_LOWER &&
				(c inside {[8'h41:8'h5a]})) begin
				cc = c + ctok_pkg::CASE_OFFSET;
			end
		end
		if (do_store && ({1'b0, r.st.token_length} < (cap - ctok_pkg::CAP_MIN))) begin
			r.st.token_length = r.st.token_length + 1'b1;
			r.has = 1'b1;
			r.chr = cc;
		end
		return r;
	endfunction

	scan_t first_pass;
	scan_t second_pass;
	scan_t fin;
	logic  again;
	ctok_pkg::out_t pre_res;
	ctok_pkg::out_t fin_res;
	logic  fin_valid;

	// first pass, and a rescan from white mode when the terminator is kept
	always_comb begin
		first_pass  = scan_once(cur, item.ch, item.last_in_line, cfg);
		again       = (first_pass.status == ctok_pkg::SCAN_AGAIN);
		second_pass = scan_once(ctok_pkg::TOK_CLEAR, item.ch, item.last_in_line, cfg);
		fin         = again ? second_pass : first_pass;

		pre_res              = '0;
		pre_res.token_end    = 1'b1;
		pre_res.breaker_char = first_pass.brk;
		pre_res.was_quoted   = first_pass.st.quoted_flag;
	end

	// result of the consuming pass and the state left behind
	always_comb begin
		fin_res   = '0;
		fin_valid = 1'b0;
		nxt       = fin.st;
		if (fin.status == ctok_pkg::SCAN_ENDED) begin
			fin_valid            = 1'b1;
			fin_res.token_end    = 1'b1;
			fin_res.breaker_char = fin.brk;
			fin_res.was_quoted   = fin.st.quoted_flag;
			fin_res.line_end     = item.last_in_line;
			nxt                  = ctok_pkg::TOK_CLEAR;
		end else if (item.last_in_line) begin
			fin_valid          = 1'b1;
			fin_res.has_char   = fin.has;
			fin_res.char_out   = fin.chr;
			fin_res.token_end  = 1'b1;
			fin_res.was_quoted = fin.st.quoted_flag;
			fin_res.line_end   = 1'b1;
			nxt                = ctok_pkg::TOK_CLEAR;
		end else if (fin.has) begin
			fin_valid        = 1'b1;
			fin_res.has_char = 1'b1;
			fin_res.char_out = fin.chr;
		end
	end

	// order the transactions: forced token end goes first
	always_comb begin
		step = '0;
		if (again) begin
			step.first_valid  = 1'b1;
			step.first        = pre_res;
			step.second_valid = fin_valid;
			step.second       = fin_res;
		end else begin
			step.first_valid = fin_valid;
			step.first       = fin_res;
		end
	end

endmodule

// File: sv/configurable_char_tokenizer.sv
// configurable_char_tokenizer: top level of the quote- and escape-aware tokenizer
// depends on ctok_pkg and ctok_scan
//
// The tokenizer takes one character per cycle, unless the output side stalls,
// and emits token characters and token-end transactions. A character goes
// through an input register, is scanned combinationally against the current
// state, and its results land in the output register; a character waits in
// the input register until the output register can take its results. Most
// characters give zero or one result and, with the output side ready, sustain
// one character per cycle. A character that ends a finished token and then
// starts a new one (a quote after a token, or an ordinary or escape character
// after a blank-ended or quote-closed token) can give two results; the second
// waits in a hold register, and the scan does not advance until the output
// register has taken it over from the hold register. Configuration writes take
// effect at the next edge and are expected only while the block is idle.
module configurable_char_tokenizer (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [ctok_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [ctok_pkg::CFG_DATA_W-1:0]     cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  ctok_pkg::in_t                       in_data,
	output logic                                out_valid,
	input  logic                                out_ready,
	output ctok_pkg::out_t                      out_data
);

	ctok_pkg::cfg_t       cfg_q;
	ctok_pkg::tok_state_t state_q;
	ctok_pkg::tok_state_t state_nxt;
	ctok_pkg::step_t      step;
	ctok_pkg::in_t        item_s1;
	logic                 valid_s1;
	ctok_pkg::out_t       out_q;
	logic                 out_valid_q;
	ctok_pkg::out_t       hold_q;
	logic                 hold_valid_q;
	logic                 adv;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.blank_chars     <= ctok_pkg::BLANK_RESET;
			cfg_q.separator_chars <= ctok_pkg::SEP_RESET;
			cfg_q.quote_chars     <= ctok_pkg::QUOTE_RESET;
			cfg_q.escape_code     <= ctok_pkg::ESCAPE_RESET;
			cfg_q.case_mode       <= ctok_pkg::CASE_RESET;
			cfg_q.token_capacity  <= ctok_pkg::CAPACITY_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				ctok_pkg::REG_BLANK:    cfg_q.blank_chars <= cfg_data[ctok_pkg::SET_W-1:0];
				ctok_pkg::REG_SEP:      cfg_q.separator_chars <= cfg_data[ctok_pkg::SET_W-1:0];
				ctok_pkg::REG_QUOTE:    cfg_q.quote_chars <= cfg_data[ctok_pkg::SET_W-1:0];
				ctok_pkg::REG_ESCAPE:   cfg_q.escape_code <= cfg_data[ctok_pkg::CHAR_W-1:0];
				ctok_pkg::REG_CASE:     cfg_q.case_mode <= cfg_data[1:0];
				ctok_pkg::REG_CAPACITY: cfg_q.token_capacity <= cfg_data[ctok_pkg::CAP_W-1:0];
				default: begin
				end
			endcase
		end
	end

	// scan advances when the output stage can take two results
	assign adv      = valid_s1 && (!out_valid_q || out_ready) && !hold_valid_q;
	assign in_ready = !valid_s1 || adv;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			item_s1 <= in_data;
		end
	end

	ctok_scan u_scan (
		.cfg  (cfg_q),
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.step (step)
	);

	// tokenizer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ctok_pkg::TOK_CLEAR;
		end else if (adv) begin
			state_q <= state_nxt;
		end
	end

	// output register and hold register for the second result
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			hold_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q  <= step.first_valid;
			hold_valid_q <= step.second_valid;
		end else if (out_valid_q && out_ready) begin
			out_valid_q  <= hold_valid_q;
			hold_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_q  <= step.first;
			hold_q <= step.second;
		end else if (out_valid_q && out_ready && hold_valid_q) begin
			out_q <= hold_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

endmodule

// File: sv/ctok_checker.sv
// ctok_checker: port-level assertions for configurable_char_tokenizer, bound below
// depends on ctok_pkg and configurable_char_tokenizer_macros.svh
`include "configurable_char_tokenizer_macros.svh"

module ctok_checker (
	input logic           clk,
	input logic           arst_n,
	input logic           out_valid,
	input logic           out_ready,
	input ctok_pkg::out_t out_data
);

	// a result without a token end always carries a character
	`CTOK_ASSERT_NOW(a_char_or_end, out_valid && !out_data.token_end, out_data.has_char, "result with neither char nor token end")

	// breaker and quoted flag only on a token end
	`CTOK_ASSERT_NOW(a_end_fields, out_valid && !out_data.token_end, out_data.breaker_char == '0 && !out_data.was_quoted, "token-end fields set without token end")

	// line end always closes the token
	`CTOK_ASSERT_NOW(a_line_closes, out_valid && out_data.line_end, out_data.token_end, "line end without token end")

	// a stalled transaction holds
	`CTOK_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_data), "output changed while stalled")

endmodule

bind configurable_char_tokenizer ctok_checker u_ctok_checker (.*);

// File: dv/tb.sv
// tb: self-checking bench for configurable_char_tokenizer, one character per transaction
// needs ctok_pkg and the tokenizer RTL; a scoreboard class predicts every result
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import ctok_pkg::*;

	localparam int WATCHDOG   = 3000;
	localparam int LONG_HOLD  = 400;
	localparam int SETTLE     = 8;
	localparam int MAX_LINE   = 12;
	localparam logic [1:0] CASE_KEEP_ALT = 2'd3;
	localparam logic [CHAR_W-1:0] BACKSLASH = 8'h5C;

	// scoreboard: own copy of the tokenizer state and registers
	class token_scoreboard;
		cfg_t cfg;
		mode_t mode;
		logic [CHAR_W-1:0] open_q;
		bit esc_wait;
		int unsigned tok_len;
		bit quoted;
		bit cur_has;
		logic [CHAR_W-1:0] cur_chr;
		logic [CHAR_W-1:0] cur_brk;
		out_t expected_results[$];
		int mismatches;
		int compared;

		function new();
			cfg = '{BLANK_RESET, SEP_RESET, QUOTE_RESET, ESCAPE_RESET, CASE_RESET,
				CAPACITY_RESET};
			mismatches = 0;
			compared = 0;
			clear_token();
		endfunction

		function void clear_token();
			mode = MODE_WHITE;
			open_q = '0;
			esc_wait = 1'b0;
			tok_len = 0;
			quoted = 1'b0;
		endfunction

		function bit in_set(logic [SET_W-1:0] set, logic [CHAR_W-1:0] c);
			for (int s = 0; s < SET_SLOTS; s++) begin
				if (set[s*SLOT_W +: SLOT_W] != '0 && set[s*SLOT_W +: SLOT_W] == c)
					return 1'b1;
			end
			return 1'b0;
		endfunction

		// store one character unless the token is full
		function void keep_char(logic [CHAR_W-1:0] c);
			int unsigned cap;
			logic [CHAR_W-1:0] v;
			cap = cfg.token_capacity;
			if (cap < CAP_MIN) cap = CAP_MIN;
			if (cap > CAP_MAX) cap = CAP_MAX;
			if (tok_len >= cap - 1) return;
			tok_len++;
			v = c;
			if (mode != MODE_QUOTE) begin
				if (cfg.case_mode == CASE_UPPER && v >= "a" && v <= "z")
					v = v - CASE_OFFSET;
				else if (cfg.case_mode == CASE_LOWER && v >= "A" && v <= "Z")
					v = v + CASE_OFFSET;
			end
			cur_has = 1'b1;
			cur_chr = v;
		endfunction

		// one pass of the state machine over a character
		function scan_status_t scan_char(logic [CHAR_W-1:0] c, bit last);
			bit is_esc;
			if (esc_wait) begin
				esc_wait = 1'b0;
				keep_char(c);
				return SCAN_CONSUMED;
			end
			if (in_set(cfg.separator_chars, c)) begin
				if (mode != MODE_QUOTE) begin
					cur_brk = c;
					return SCAN_ENDED;
				end
				keep_char(c);
			end else if (in_set(cfg.quote_chars, c)) begin
				case (mode)
					MODE_WHITE: begin
						mode = MODE_QUOTE;
						open_q = c;
						quoted = 1'b1;
					end
					MODE_QUOTE: begin
						if (c != open_q) begin
							keep_char(c);
						end else begin
							mode = MODE_AFTER;
							open_q = '0;
						end
					end
					default: begin
						cur_brk = c;
						return SCAN_AGAIN;
					end
				endcase
			end else if (in_set(cfg.blank_chars, c)) begin
				if (mode == MODE_TOKEN) mode = MODE_AFTER;
				else if (mode == MODE_QUOTE) keep_char(c);
			end else begin
				// escape or ordinary character
				is_esc = cfg.escape_code != '0 && c == cfg.escape_code && !last;
				if (mode == MODE_AFTER) begin
					cur_brk = '0;
					return SCAN_AGAIN;
				end
				if (mode == MODE_WHITE) mode = MODE_TOKEN;
				if (is_esc) esc_wait = 1'b1;
				else keep_char(c);
			end
			return SCAN_CONSUMED;
		endfunction

		function void push_result(bit has, logic [CHAR_W-1:0] chr, bit fin,
				logic [CHAR_W-1:0] brk, bit q, bit le);
			out_t r;
			r.has_char = has;
			r.char_out = chr;
			r.token_end = fin;
			r.breaker_char = brk;
			r.was_quoted = q;
			r.line_end = le;
			expected_results.push_back(r);
		endfunction

		// accepted character: predict its results
		function void note_char(in_t d);
			scan_status_t st;
			cur_has = 1'b0;
			cur_chr = '0;
			cur_brk = '0;
			st = scan_char(d.ch, d.last_in_line);
			if (st == SCAN_AGAIN) begin
				// finished token closed, character scanned again from white
				push_result(1'b0, '0, 1'b1, cur_brk, quoted, 1'b0);
				clear_token();
				cur_has = 1'b0;
				cur_chr = '0;
				cur_brk = '0;
				st = scan_char(d.ch, d.last_in_line);
			end
			if (st == SCAN_ENDED) begin
				push_result(1'b0, '0, 1'b1, cur_brk, quoted, d.last_in_line);
				clear_token();
			end else if (d.last_in_line) begin
				push_result(cur_has, cur_chr, 1'b1, '0, quoted, 1'b1);
				clear_token();
			end else if (cur_has) begin
				push_result(1'b1, cur_chr, 1'b0, '0, 1'b0, 1'b0);
			end
		endfunction

		function void compare_field(string name, logic [CHAR_W-1:0] e,
				logic [CHAR_W-1:0] a);
			if (a !== e) begin
				mismatches++;
				$display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
			end
		endfunction

		// accepted result against the oldest expectation
		function void check_result(out_t got);
			out_t exp;
			if (expected_results.size() == 0) begin
				mismatches++;
				$display("%0t: unexpected result, expected none, actual %h", $time, got);
				return;
			end
			exp = expected_results.pop_front();
			compared++;
			compare_field("has_char", exp.has_char, got.has_char);
			compare_field("char_out", exp.char_out, got.char_out);
			compare_field("token_end", exp.token_end, got.token_end);
			compare_field("breaker_char", exp.breaker_char, got.breaker_char);
			compare_field("was_quoted", exp.was_quoted, got.was_quoted);
			compare_field("line_end", exp.line_end, got.line_end);
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;
	logic in_valid;
	logic in_ready;
	in_t in_data;
	logic out_valid;
	logic out_ready = 1'b0;
	out_t out_data;

	token_scoreboard sb;
	int snd_idle_pct = 0;
	int rcv_stall_pct = 0;
	bit long_hold = 1'b0;
	event long_hold_go;
	int quiet_cycles = 0;
	int chars_sent = 0;
	int configs_used = 0;

	configurable_char_tokenizer uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data)
	);

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// receiver: random stalls plus an occasional long hold-off
	always @(posedge clk) begin
		out_ready <= !long_hold && ($urandom_range(99) >= rcv_stall_pct);
	end

	initial begin
		forever begin
			@(long_hold_go);
			@(negedge clk);
			long_hold = 1'b1;
			repeat (LONG_HOLD) @(negedge clk);
			long_hold = 1'b0;
		end
	end

	// result monitor and watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready) sb.check_result(out_data);
			if ((out_valid && out_ready) || (in_valid && in_ready)) quiet_cycles = 0;
			else quiet_cycles++;
			if (quiet_cycles >= WATCHDOG) begin
				$display("%0t: no transaction for %0d cycles", $time, WATCHDOG);
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	function automatic logic [CHAR_W-1:0] random_letter();
		if ($urandom_range(1)) return 8'h61 + 8'($urandom_range(25));
		return 8'h41 + 8'($urandom_range(25));
	endfunction

	function automatic logic [CHAR_W-1:0] member_of(logic [SET_W-1:0] set);
		logic [CHAR_W-1:0] b;
		for (int k = 0; k < SET_SLOTS; k++) begin
			b = set[SLOT_W*$urandom_range(SET_SLOTS-1) +: SLOT_W];
			if (b != '0) return b;
		end
		return random_letter();
	endfunction

	// characters the current registers treat specially, letters and some noise
	function automatic logic [CHAR_W-1:0] pick_char(cfg_t c);
		int r;
		r = $urandom_range(99);
		if (r < 30) return random_letter();
		if (r < 45) return member_of(c.blank_chars);
		if (r < 57) return member_of(c.separator_chars);
		if (r < 72) return member_of(c.quote_chars);
		if (r < 80) return (c.escape_code != '0) ? c.escape_code : random_letter();
		return 8'($urandom_range(255, 1));
	endfunction

	task automatic push_char(in_t d);
		while ($urandom_range(99) < snd_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		sb.note_char(d);
		chars_sent++;
	endtask

	task automatic send_text(string s);
		for (int i = 0; i < s.len(); i++)
			push_char(in_t'{ch: s[i], last_in_line: (i == s.len() - 1)});
	endtask

	task automatic run_random(int n);
		int sent;
		int len;
		sent = 0;
		while (sent < n) begin
			len = $urandom_range(MAX_LINE, 1);
			for (int i = 0; i < len; i++)
				push_char(in_t'{ch: pick_char(sb.cfg), last_in_line: (i == len - 1)});
			sent += len;
		end
	endtask

	// stop sending and let every expected result come out
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (sb.expected_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
	endtask

	task automatic program_regs(cfg_t c);
		write_reg(REG_BLANK, c.blank_chars);
		write_reg(REG_SEP, c.separator_chars);
		write_reg(REG_QUOTE, c.quote_chars);
		write_reg(REG_ESCAPE, CFG_DATA_W'(c.escape_code));
		write_reg(REG_CASE, CFG_DATA_W'(c.case_mode));
		write_reg(REG_CAPACITY, CFG_DATA_W'(c.token_capacity));
		cfg_we <= 1'b0;
		sb.cfg = c;
		configs_used++;
	endtask

	initial begin
		cfg_t c;
		sb = new();
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		in_data = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed lines: blank and comma/semicolon breaks, backslash escape,
		// upper-casing and a token capacity of four, which keeps three characters
		c = '{64'h0920, 64'h3B2C, QUOTE_RESET, BACKSLASH, CASE_UPPER, 13'd4};
		program_regs(c);
		send_text("ab,,");
		send_text("\"q,\"b");
		send_text("x 'y");
		send_text("\\,a\\");
		send_text("abcde");
		send_text($sformatf("%c %c%c", 8'hFF, BACKSLASH, 8'h01));
		wait_drained();

		// no idling, typical sets
		c = '{64'h0920, 64'h3B2C, 64'h2227, BACKSLASH, CASE_RESET, 13'd256};
		program_regs(c);
		run_random(100);
		wait_drained();

		// sender mostly idle; no blanks, all-ones separators, minimum capacity keeping no characters
		c = '{64'h0, {SET_W{1'b1}}, 64'h2227_6071_0000_2A00, 8'hFF, CASE_UPPER, CAP_MIN};
		program_regs(c);
		snd_idle_pct = 75;
		run_random(100);
		wait_drained();

		// receiver mostly stalled; random sets, largest buffer
		c = '{{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom},
			8'($urandom), CASE_LOWER, CAP_MAX};
		program_regs(c);
		snd_idle_pct = 0;
		rcv_stall_pct = 75;
		run_random(100);
		wait_drained();

		// both sides idle now and then, with a full pause midway
		c = '{64'h0A_2009, 64'h7C3B_3A2C, {SET_W{1'b1}}, BACKSLASH, CASE_KEEP_ALT, 13'd5};
		program_regs(c);
		snd_idle_pct = 22;
		rcv_stall_pct = 22;
		run_random(50);
		wait_drained();
		run_random(50);
		wait_drained();

		// long receiver hold-off while characters keep coming
		c = '{{SET_W{1'b1}}, 64'h2C, 64'h2227, 8'h5E, CASE_UPPER, 13'd3};
		program_regs(c);
		snd_idle_pct = 0;
		rcv_stall_pct = 0;
		-> long_hold_go;
		run_random(100);
		wait_drained();

		$display("covered %0d characters under %0d register settings, idle and stall mixes",
			chars_sent, configs_used);
		$display("%0d results compared, %0d mismatches", sb.compared, sb.mismatches);
		if (sb.mismatches == 0 && sb.expected_results.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end
endmodule

// File: files.f
+incdir+sv
sv/ctok_pkg.sv
sv/ctok_scan.sv
sv/configurable_char_tokenizer.sv
sv/ctok_checker.sv
dv/tb.sv
